// ===== design/mqufi_pkg.sv =====
// Shared types, constants and helper functions of the multi-queue block.
// Used by every module in the design folder; it depends on nothing else.
package mqufi_pkg;

    localparam int NUM_QUEUES     = 32;
    localparam int QUEUE_DEPTH    = 8;
    localparam int TAG_WIDTH      = 16;

    localparam int QSEL_WIDTH     = 5;
    localparam int ITEM_TAG_WIDTH = 16;
    localparam int LIMIT_WIDTH    = 4;
    localparam int OCC_WIDTH      = 4;
    localparam int CODE_WIDTH     = 2;

    localparam int QIDX_WIDTH     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CNT_WIDTH      = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_WIDTH      = (CNT_WIDTH > LIMIT_WIDTH) ? CNT_WIDTH : LIMIT_WIDTH;

    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(8);

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_SERVE = 1'b1;

    typedef logic [TAG_WIDTH-1:0] tag_t;

    typedef struct packed {
        tag_t tag;
        logic urgent;
    } entry_t;

    typedef enum logic [CODE_WIDTH-1:0] {
        RES_ADDED  = 2'd0,
        RES_FULL   = 2'd1,
        RES_SERVED = 2'd2,
        RES_EMPTY  = 2'd3
    } result_code_t;

    typedef enum logic [1:0] {
        Q_IDLE      = 2'd0,
        Q_PUSH_HEAD = 2'd1,
        Q_PUSH_TAIL = 2'd2,
        Q_POP       = 2'd3
    } q_op_t;

    typedef struct packed {
        q_op_t  op;
        entry_t entry;
    } q_cmd_t;

    typedef enum logic [1:0] {
        SLOT_HOLD      = 2'd0,
        SLOT_FROM_PREV = 2'd1,
        SLOT_FROM_NEXT = 2'd2,
        SLOT_LOAD      = 2'd3
    } slot_op_t;

    // Stored tags keep the low TAG_WIDTH bits of the incoming tag.
    function automatic tag_t tag_from_item(input logic [ITEM_TAG_WIDTH-1:0] x);
        tag_t r;
        r = '0;
        for (int i = 0; i < TAG_WIDTH; i++) begin
            if (i < ITEM_TAG_WIDTH) begin
                r[i] = x[i];
            end
        end
        return r;
    endfunction

    // The result carries the low bits of a stored tag, zero-extended.
    function automatic logic [ITEM_TAG_WIDTH-1:0] item_from_tag(input tag_t x);
        logic [ITEM_TAG_WIDTH-1:0] r;
        r = '0;
        for (int i = 0; i < ITEM_TAG_WIDTH; i++) begin
            if (i < TAG_WIDTH) begin
                r[i] = x[i];
            end
        end
        return r;
    endfunction

    function automatic logic [QIDX_WIDTH-1:0] idx_from_sel(input logic [QSEL_WIDTH-1:0] s);
        logic [QIDX_WIDTH-1:0] r;
        r = '0;
        for (int i = 0; i < QIDX_WIDTH; i++) begin
            if (i < QSEL_WIDTH) begin
                r[i] = s[i];
            end
        end
        return r;
    endfunction

endpackage

// ===== design/mqufi_slot.sv =====
// One storage cell of a queue: holds a tag and its urgent flag.
// Depends on mqufi_pkg; chained by mqufi_queue.
module mqufi_slot import mqufi_pkg::*; (
    input  logic     aclk,
    input  slot_op_t op,
    input  entry_t   prev_entry,
    input  entry_t   next_entry,
    input  entry_t   new_entry,
    output entry_t   entry
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb begin
        case (op)
            SLOT_HOLD:      entry_next = entry_reg;
            SLOT_FROM_PREV: entry_next = prev_entry;
            SLOT_FROM_NEXT: entry_next = next_entry;
            SLOT_LOAD:      entry_next = new_entry;
            default:        entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== design/mqufi_queue.sv =====
// One bounded deque: a chain of slot cells with the head in slot zero, plus its count.
// Depends on mqufi_pkg and mqufi_slot.
module mqufi_queue import mqufi_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  q_cmd_t               cmd,
    output entry_t               head,
    output logic [CNT_WIDTH-1:0] count
);

    logic [CNT_WIDTH-1:0] count_reg;
    logic [CNT_WIDTH-1:0] count_next;
    entry_t               slot_q   [QUEUE_DEPTH];
    slot_op_t             slot_ops [QUEUE_DEPTH];

    // The caller only issues legal commands: no push when full, no pop when empty.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            case (cmd.op)
                Q_PUSH_HEAD: slot_ops[i] = SLOT_FROM_PREV;
                Q_PUSH_TAIL: slot_ops[i] = (CNT_WIDTH'(i) == count_reg) ? SLOT_LOAD : SLOT_HOLD;
                Q_POP:       slot_ops[i] = (i == QUEUE_DEPTH - 1) ? SLOT_HOLD : SLOT_FROM_NEXT;
                default:     slot_ops[i] = SLOT_HOLD;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
            entry_t prev_e;
            entry_t next_e;
            if (g == 0) begin : g_first
                // An urgent item enters the head as the rest shift one place back.
                assign prev_e = cmd.entry;
            end else begin : g_mid
                assign prev_e = slot_q[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign next_e = slot_q[g];
            end else begin : g_inner
                assign next_e = slot_q[g+1];
            end
            mqufi_slot u_slot (
                .aclk       (aclk),
                .op         (slot_ops[g]),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .new_entry  (cmd.entry),
                .entry      (slot_q[g])
            );
        end
    endgenerate

    always_comb begin
        case (cmd.op)
            Q_PUSH_HEAD: count_next = count_reg + CNT_WIDTH'(1);
            Q_PUSH_TAIL: count_next = count_reg + CNT_WIDTH'(1);
            Q_POP:       count_next = count_reg - CNT_WIDTH'(1);
            default:     count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign head  = slot_q[0];
    assign count = count_reg;

endmodule

// ===== design/multi_queue_urgent_front_insert_top.sv =====
// Top level of the multi-queue block: request register, per-queue cell chains, result register.
// Depends on mqufi_pkg and mqufi_queue.
//
//   Channel  | Ports                                              | Direction
//   request  | s_valid s_ready s_req_type s_queue_sel s_item_tag  | in
//            | s_urgent                                           |
//   result   | m_valid m_ready m_result_code m_served_tag         | out
//            | m_served_urgent m_occupancy                        |
//   config   | cfg_wen cfg_wdata (queue limit)                    | in
//
// One request is taken per cycle while results are taken; each result is registered on execution.
// The addressed queue's cell chain shifts or loads as the request executes, so a following
// request on the same queue sees the updated contents with no extra wait.
// After reset every queue is empty and the limit is eight; there is no clearing pass.
// While m_ready is low the result holds, one further request waits in the request
// register, and s_ready then drops until the result is taken.
module multi_queue_urgent_front_insert_top import mqufi_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_req_type,
    input  logic [QSEL_WIDTH-1:0]     s_queue_sel,
    input  logic [ITEM_TAG_WIDTH-1:0] s_item_tag,
    input  logic                      s_urgent,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [CODE_WIDTH-1:0]     m_result_code,
    output logic [ITEM_TAG_WIDTH-1:0] m_served_tag,
    output logic                      m_served_urgent,
    output logic [OCC_WIDTH-1:0]      m_occupancy,
    input  logic                      cfg_wen,
    input  logic [LIMIT_WIDTH-1:0]    cfg_wdata
);

    logic                      req_valid_reg;
    logic                      req_type_reg;
    logic [QSEL_WIDTH-1:0]     req_sel_reg;
    logic [ITEM_TAG_WIDTH-1:0] req_tag_reg;
    logic                      req_urgent_reg;

    logic [LIMIT_WIDTH-1:0]    limit_reg;

    logic                      m_valid_reg;
    result_code_t              code_reg;
    logic [ITEM_TAG_WIDTH-1:0] stag_reg;
    logic                      surg_reg;
    logic [OCC_WIDTH-1:0]      occ_reg;

    logic                      exec;
    logic                      in_range;
    logic [QIDX_WIDTH-1:0]     qidx;
    logic [CNT_WIDTH-1:0]      cur_cnt;
    entry_t                    cur_head;
    logic [CMP_WIDTH-1:0]      lim_eff;
    q_op_t                     sel_op;
    result_code_t              code_next;
    logic [ITEM_TAG_WIDTH-1:0] stag_next;
    logic                      surg_next;
    logic [OCC_WIDTH-1:0]      occ_next;
    entry_t                    new_entry;

    q_cmd_t                    q_cmds   [NUM_QUEUES];
    entry_t                    q_heads  [NUM_QUEUES];
    logic [CNT_WIDTH-1:0]      q_counts [NUM_QUEUES];

    assign exec    = req_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !req_valid_reg || exec;

    assign in_range = (32'(req_sel_reg) < NUM_QUEUES);
    assign qidx     = idx_from_sel(req_sel_reg);
    assign cur_cnt  = q_counts[qidx];
    assign cur_head = q_heads[qidx];

    // A limit above the queue depth acts as the depth.
    assign lim_eff = (CMP_WIDTH'(limit_reg) > CMP_WIDTH'(QUEUE_DEPTH)) ?
                     CMP_WIDTH'(QUEUE_DEPTH) : CMP_WIDTH'(limit_reg);

    assign new_entry.tag    = tag_from_item(req_tag_reg);
    assign new_entry.urgent = req_urgent_reg;

    always_comb begin
        sel_op    = Q_IDLE;
        code_next = RES_FULL;
        stag_next = '0;
        surg_next = 1'b0;
        occ_next  = '0;
        if (!in_range) begin
            code_next = (req_type_reg == REQ_SERVE) ? RES_EMPTY : RES_FULL;
        end else if (req_type_reg == REQ_ADD) begin
            if (CMP_WIDTH'(cur_cnt) >= lim_eff) begin
                code_next = RES_FULL;
                occ_next  = OCC_WIDTH'(cur_cnt);
            end else begin
                code_next = RES_ADDED;
                sel_op    = req_urgent_reg ? Q_PUSH_HEAD : Q_PUSH_TAIL;
                occ_next  = OCC_WIDTH'(cur_cnt + CNT_WIDTH'(1));
            end
        end else begin
            if (cur_cnt == '0) begin
                code_next = RES_EMPTY;
            end else begin
                code_next = RES_SERVED;
                sel_op    = Q_POP;
                stag_next = item_from_tag(cur_head.tag);
                surg_next = cur_head.urgent;
                occ_next  = OCC_WIDTH'(cur_cnt - CNT_WIDTH'(1));
            end
        end
    end

    always_comb begin
        for (int q = 0; q < NUM_QUEUES; q++) begin
            q_cmds[q].entry = new_entry;
            q_cmds[q].op    = (exec && in_range && (qidx == QIDX_WIDTH'(q))) ? sel_op : Q_IDLE;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_QUEUES; g++) begin : g_queue
            mqufi_queue u_queue (
                .aclk    (aclk),
                .aresetn (aresetn),
                .cmd     (q_cmds[g]),
                .head    (q_heads[g]),
                .count   (q_counts[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            limit_reg     <= LIMIT_RESET;
        end else begin
            if (s_valid && s_ready) begin
                req_valid_reg <= 1'b1;
            end else if (exec) begin
                req_valid_reg <= 1'b0;
            end
            if (exec) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wen) begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_type_reg   <= s_req_type;
            req_sel_reg    <= s_queue_sel;
            req_tag_reg    <= s_item_tag;
            req_urgent_reg <= s_urgent;
        end
        if (exec) begin
            code_reg <= code_next;
            stag_reg <= stag_next;
            surg_reg <= surg_next;
            occ_reg  <= occ_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_code   = code_reg;
    assign m_served_tag    = stag_reg;
    assign m_served_urgent = surg_reg;
    assign m_occupancy     = occ_reg;

    // A request that is executed always leaves a result behind.
    a_exec_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        exec |=> m_valid)
        else $error("executed request left no result");

    // Occupancy never exceeds the depth of a queue.
    a_occ_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_occupancy) <= QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    // Only a served result carries a tag or an urgent flag.
    a_tag_only_served: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_code != RES_SERVED)) |->
            ((m_served_tag == '0) && !m_served_urgent))
        else $error("tag reported on a result that served nothing");

    // An empty answer reports an empty queue.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_code == RES_EMPTY)) |-> (m_occupancy == '0))
        else $error("empty result with non-zero occupancy");

endmodule
